>>> rtl/core/swaf_pkg.sv
// Shared constants, types and codes of the sensor window average forecast core.
`timescale 1ns / 1ps
package swaf_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int CHANNELS    = 5;
  localparam int CH_W        = $clog2(CHANNELS);

  localparam int HUM_W  = 8;
  localparam int TEMP_W = 8;
  localparam int PM_W   = 10;
  localparam int X_W    = 11;

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int PSUM_W  = X_W + $clog2(MAX_SAMPLES);
  localparam int USUM_W  = PSUM_W + $clog2(MAX_SAMPLES);
  localparam int PROD_W  = PSUM_W + CNT_W + 1;
  localparam int DVD_W   = PROD_W - 1;
  localparam int DVS_W   = $clog2(MAX_SAMPLES * (MAX_SAMPLES + 1) / 2 + 1);
  localparam int DSTEP_W = $clog2(DVD_W);

  localparam int DIV5_MUL   = 13108;
  localparam int DIV5_SHIFT = 16;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] MODE_PLAIN    = 2'd0;
  localparam logic [1:0] MODE_WEIGHTED = 2'd1;
  localparam logic [1:0] MODE_EXP      = 2'd2;

  typedef logic signed [X_W-1:0] chan_t;

  typedef struct packed {
    logic [CHANNELS-1:0][X_W-1:0] x;
    logic                         keep;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/sensor_window_average_forecast_core.sv
// Top level of the sensor window average forecast core.
// Sample beats enter on the in_ channel (valid/stall), one five-channel sample per beat;
// in_last_sample closes a window. One forecast beat leaves on the out_ channel per window.
// cfg_wr_en/cfg_wr_data set the averaging mode: plain, linearly weighted or exponential.
// In the engine each kept sample is popped, then accumulated channel by channel; dropped
// samples are only popped. Two queue entries sit ahead of the engine, so input beats are
// taken back to back until the queue fills.
// At the closing sample the engine runs the shared 32-step divider once per channel in
// plain and weighted modes; in exponential mode it copies the smoothed values instead.
// Only 1024 samples per window enter the average; later ones are dropped and the
// forecast reports window_overflow.
// A forecast waits in the output register while out_stall is high; meanwhile the engine
// keeps accumulating the next window and only holds before its own forecast.
// Synchronous reset clears the window, the queue and out_valid, and sets plain mode.
`timescale 1ns / 1ps
module sensor_window_average_forecast_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [1:0]                         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [swaf_pkg::HUM_W-1:0]         in_humidity,
  input  logic signed [swaf_pkg::TEMP_W-1:0] in_temperature,
  input  logic [swaf_pkg::PM_W-1:0]          in_pm25,
  input  logic [swaf_pkg::PM_W-1:0]          in_pm1,
  input  logic [swaf_pkg::PM_W-1:0]          in_pm10,
  input  logic                               in_last_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [swaf_pkg::HUM_W-1:0]         out_forecast_humidity,
  output logic signed [swaf_pkg::TEMP_W-1:0] out_forecast_temperature,
  output logic [swaf_pkg::PM_W-1:0]          out_forecast_pm25,
  output logic [swaf_pkg::PM_W-1:0]          out_forecast_pm1,
  output logic [swaf_pkg::PM_W-1:0]          out_forecast_pm10,
  output logic [swaf_pkg::CNT_W-1:0]         out_samples_used,
  output logic                               out_window_overflow
);

  logic [1:0]         mode_r;
  swaf_pkg::q_stat_t  q_stat;
  swaf_pkg::item_t    push_item;
  swaf_pkg::item_t    pop_item;
  logic               push;
  logic               pop;
  swaf_pkg::div_req_t div_req;
  swaf_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= swaf_pkg::MODE_PLAIN;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  swaf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_humidity    (in_humidity),
    .in_temperature (in_temperature),
    .in_pm25        (in_pm25),
    .in_pm1         (in_pm1),
    .in_pm10        (in_pm10),
    .in_last_sample (in_last_sample),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  swaf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  swaf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  swaf_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .mode                     (mode_r),
    .q_stat                   (q_stat),
    .pop_item                 (pop_item),
    .pop                      (pop),
    .div_req                  (div_req),
    .div_rsp                  (div_rsp),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_forecast_humidity    (out_forecast_humidity),
    .out_forecast_temperature (out_forecast_temperature),
    .out_forecast_pm25        (out_forecast_pm25),
    .out_forecast_pm1         (out_forecast_pm1),
    .out_forecast_pm10        (out_forecast_pm10),
    .out_samples_used         (out_samples_used),
    .out_window_overflow      (out_window_overflow)
  );

endmodule

>>> rtl/core/swaf_front.sv
// Input side: accepts sample beats, widens channels and marks samples kept or dropped.
`timescale 1ns / 1ps
module swaf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [swaf_pkg::HUM_W-1:0]  in_humidity,
  input  logic signed [swaf_pkg::TEMP_W-1:0] in_temperature,
  input  logic [swaf_pkg::PM_W-1:0]   in_pm25,
  input  logic [swaf_pkg::PM_W-1:0]   in_pm1,
  input  logic [swaf_pkg::PM_W-1:0]   in_pm10,
  input  logic                        in_last_sample,
  input  swaf_pkg::q_stat_t           q_stat,
  output logic                        push,
  output swaf_pkg::item_t             push_item
);

  logic [swaf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       accept;
  logic                       keep;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign push     = accept;
  assign keep     = cnt_r < swaf_pkg::CNT_W'(swaf_pkg::MAX_SAMPLES);

  always_comb begin
    push_item.x[0] = {{(swaf_pkg::X_W - swaf_pkg::HUM_W){1'b0}}, in_humidity};
    push_item.x[1] = {{(swaf_pkg::X_W - swaf_pkg::TEMP_W){in_temperature[swaf_pkg::TEMP_W-1]}},
                      in_temperature};
    push_item.x[2] = {{(swaf_pkg::X_W - swaf_pkg::PM_W){1'b0}}, in_pm25};
    push_item.x[3] = {{(swaf_pkg::X_W - swaf_pkg::PM_W){1'b0}}, in_pm1};
    push_item.x[4] = {{(swaf_pkg::X_W - swaf_pkg::PM_W){1'b0}}, in_pm10};
    push_item.keep = keep;
    push_item.last = in_last_sample;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_last_sample) begin
        cnt_nxt = '0;
      end else if (keep) begin
        cnt_nxt = cnt_r + swaf_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/swaf_queue.sv
// Short register queue between the input side and the averaging engine.
`timescale 1ns / 1ps
module swaf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swaf_pkg::item_t   push_item,
  input  logic              pop,
  output swaf_pkg::item_t   pop_item,
  output swaf_pkg::q_stat_t q_stat
);

  swaf_pkg::item_t             mem_r [swaf_pkg::QDEPTH];
  logic [swaf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [swaf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [swaf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign pop_item     = mem_r[rd_ptr_r];
  assign q_stat.valid = cnt_r != '0;
  assign q_stat.full  = cnt_r == swaf_pkg::QCNT_W'(swaf_pkg::QDEPTH);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == swaf_pkg::QPTR_W'(swaf_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + swaf_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == swaf_pkg::QPTR_W'(swaf_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + swaf_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + swaf_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - swaf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/swaf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module swaf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  swaf_pkg::div_req_t req,
  output swaf_pkg::div_rsp_t rsp
);

  typedef enum logic {DV_IDLE, DV_RUN} dv_state_t;

  dv_state_t                    state_r, state_nxt;
  logic [swaf_pkg::DVS_W-1:0]   rem_r, rem_nxt;
  logic [swaf_pkg::DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [swaf_pkg::DVD_W-1:0]   quo_r, quo_nxt;
  logic [swaf_pkg::DSTEP_W-1:0] step_r, step_nxt;
  logic                         done_r, done_nxt;
  logic [swaf_pkg::DVS_W:0]     trial;
  logic [swaf_pkg::DVS_W+1:0]   diff;
  logic                         fits;

  assign trial        = {rem_r, quo_r[swaf_pkg::DVD_W-1]};
  assign diff         = {1'b0, trial} - {2'b00, dvs_r};
  assign fits         = !diff[swaf_pkg::DVS_W+1];
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          rem_nxt   = '0;
          quo_nxt   = req.dividend;
          dvs_nxt   = req.divisor;
          step_nxt  = '0;
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        rem_nxt  = fits ? diff[swaf_pkg::DVS_W-1:0] : trial[swaf_pkg::DVS_W-1:0];
        quo_nxt  = {quo_r[swaf_pkg::DVD_W-2:0], fits};
        step_nxt = step_r + swaf_pkg::DSTEP_W'(1);
        if (step_r == swaf_pkg::DSTEP_W'(swaf_pkg::DVD_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = DV_IDLE;
        end
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

endmodule

>>> rtl/core/swaf_back.sv
// Averaging engine: per-channel accumulation, end-of-window division (plain and weighted modes) and result register.
`timescale 1ns / 1ps
module swaf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        mode,
  input  swaf_pkg::q_stat_t                 q_stat,
  input  swaf_pkg::item_t                   pop_item,
  output logic                              pop,
  output swaf_pkg::div_req_t                div_req,
  input  swaf_pkg::div_rsp_t                div_rsp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [swaf_pkg::HUM_W-1:0]        out_forecast_humidity,
  output logic signed [swaf_pkg::TEMP_W-1:0] out_forecast_temperature,
  output logic [swaf_pkg::PM_W-1:0]         out_forecast_pm25,
  output logic [swaf_pkg::PM_W-1:0]         out_forecast_pm1,
  output logic [swaf_pkg::PM_W-1:0]         out_forecast_pm10,
  output logic [swaf_pkg::CNT_W-1:0]        out_samples_used,
  output logic                              out_window_overflow
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHAN, ST_TOTAL, ST_MUL, ST_START, ST_WAIT, ST_EMIT
  } st_t;

  localparam int T_W  = swaf_pkg::X_W + 3;
  localparam int M5_W = swaf_pkg::X_W + swaf_pkg::DIV5_SHIFT + 2;

  st_t                               state_r, state_nxt;
  logic [swaf_pkg::CH_W-1:0]         ch_r, ch_nxt;
  swaf_pkg::item_t                   item_r, item_nxt;
  logic [swaf_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                              drop_r, drop_nxt;
  logic signed [swaf_pkg::PSUM_W-1:0] psum_r [swaf_pkg::CHANNELS];
  logic signed [swaf_pkg::PSUM_W-1:0] psum_nxt [swaf_pkg::CHANNELS];
  logic signed [swaf_pkg::USUM_W-1:0] usum_r [swaf_pkg::CHANNELS];
  logic signed [swaf_pkg::USUM_W-1:0] usum_nxt [swaf_pkg::CHANNELS];
  swaf_pkg::chan_t                   smooth_r [swaf_pkg::CHANNELS];
  swaf_pkg::chan_t                   smooth_nxt [swaf_pkg::CHANNELS];
  swaf_pkg::chan_t                   res_r [swaf_pkg::CHANNELS];
  swaf_pkg::chan_t                   res_nxt [swaf_pkg::CHANNELS];
  logic [swaf_pkg::DVS_W-1:0]        total_r, total_nxt;
  logic signed [swaf_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                              neg_r, neg_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [swaf_pkg::HUM_W-1:0]        out_hum_r, out_hum_nxt;
  logic [swaf_pkg::TEMP_W-1:0]       out_temp_r, out_temp_nxt;
  logic [swaf_pkg::PM_W-1:0]         out_pm25_r, out_pm25_nxt;
  logic [swaf_pkg::PM_W-1:0]         out_pm1_r, out_pm1_nxt;
  logic [swaf_pkg::PM_W-1:0]         out_pm10_r, out_pm10_nxt;
  logic [swaf_pkg::CNT_W-1:0]        out_used_r, out_used_nxt;
  logic                              out_ovf_r, out_ovf_nxt;

  swaf_pkg::chan_t                   xs;
  logic                              first;
  logic signed [swaf_pkg::PSUM_W-1:0] pbase;
  logic signed [swaf_pkg::PSUM_W-1:0] pnew;
  logic signed [swaf_pkg::USUM_W-1:0] ubase;
  logic signed [T_W-1:0]             t5;
  logic                              t5_neg;
  logic [T_W-1:0]                    t5_mag;
  logic [M5_W-1:0]                   p5;
  swaf_pkg::chan_t                   q5;
  logic [swaf_pkg::CNT_W-1:0]        cnt_p1;
  logic [2*swaf_pkg::CNT_W-1:0]      tot_full;
  logic                              weighted;
  logic                              last_ch;
  logic signed [swaf_pkg::PROD_W-1:0] dvd;
  logic signed [swaf_pkg::PROD_W-1:0] dvd_mag;
  logic [swaf_pkg::DVD_W-1:0]        qsigned;
  logic                              out_free;

  assign out_valid                = out_valid_r;
  assign out_forecast_humidity    = out_hum_r;
  assign out_forecast_temperature = out_temp_r;
  assign out_forecast_pm25        = out_pm25_r;
  assign out_forecast_pm1         = out_pm1_r;
  assign out_forecast_pm10        = out_pm10_r;
  assign out_samples_used         = out_used_r;
  assign out_window_overflow      = out_ovf_r;

  assign pop      = (state_r == ST_IDLE) && q_stat.valid;
  assign weighted = mode == swaf_pkg::MODE_WEIGHTED;
  assign last_ch  = ch_r == swaf_pkg::CH_W'(swaf_pkg::CHANNELS - 1);
  assign cnt_p1   = cnt_r + swaf_pkg::CNT_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    xs     = swaf_pkg::chan_t'(item_r.x[ch_r]);
    first  = cnt_r == '0;
    pbase  = first ? '0 : psum_r[ch_r];
    ubase  = first ? '0 : usum_r[ch_r];
    pnew   = pbase + swaf_pkg::PSUM_W'(xs);
    t5     = T_W'(xs) + (T_W'(smooth_r[ch_r]) <<< 2);
    t5_neg = t5[T_W-1];
    t5_mag = t5_neg ? T_W'(-t5) : T_W'(t5);
    p5     = M5_W'(t5_mag) * M5_W'(swaf_pkg::DIV5_MUL);
    q5     = swaf_pkg::chan_t'(p5 >> swaf_pkg::DIV5_SHIFT);
    if (t5_neg) begin
      q5 = -q5;
    end
    tot_full = (2*swaf_pkg::CNT_W)'(cnt_r) * (2*swaf_pkg::CNT_W)'(cnt_p1);
    if (weighted) begin
      dvd = prod_r - swaf_pkg::PROD_W'(usum_r[ch_r]);
    end else begin
      dvd = swaf_pkg::PROD_W'(psum_r[ch_r]);
    end
    dvd_mag = dvd[swaf_pkg::PROD_W-1] ? -dvd : dvd;
    qsigned = neg_r ? -div_rsp.quotient : div_rsp.quotient;
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    psum_nxt      = psum_r;
    usum_nxt      = usum_r;
    smooth_nxt    = smooth_r;
    res_nxt       = res_r;
    total_nxt     = total_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hum_nxt   = out_hum_r;
    out_temp_nxt  = out_temp_r;
    out_pm25_nxt  = out_pm25_r;
    out_pm1_nxt   = out_pm1_r;
    out_pm10_nxt  = out_pm10_r;
    out_used_nxt  = out_used_r;
    out_ovf_nxt   = out_ovf_r;
    div_req.start    = 1'b0;
    div_req.dividend = dvd_mag[swaf_pkg::DVD_W-1:0];
    div_req.divisor  = weighted ? total_r : swaf_pkg::DVS_W'(cnt_r);
    case (state_r)
      ST_IDLE: begin
        if (q_stat.valid) begin
          item_nxt = pop_item;
          ch_nxt   = '0;
          if (pop_item.keep) begin
            state_nxt = ST_CHAN;
          end else begin
            drop_nxt = 1'b1;
            if (pop_item.last) begin
              state_nxt = ST_TOTAL;
            end
          end
        end
      end
      ST_CHAN: begin
        psum_nxt[ch_r]   = pnew;
        usum_nxt[ch_r]   = ubase + swaf_pkg::USUM_W'(pnew);
        smooth_nxt[ch_r] = first ? xs : q5;
        ch_nxt           = ch_r + swaf_pkg::CH_W'(1);
        if (last_ch) begin
          ch_nxt    = '0;
          cnt_nxt   = cnt_p1;
          state_nxt = item_r.last ? ST_TOTAL : ST_IDLE;
        end
      end
      ST_TOTAL: begin
        total_nxt = swaf_pkg::DVS_W'(tot_full >> 1);
        ch_nxt    = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mode == swaf_pkg::MODE_EXP) begin
          res_nxt[ch_r] = smooth_r[ch_r];
          ch_nxt        = ch_r + swaf_pkg::CH_W'(1);
          if (last_ch) begin
            state_nxt = ST_EMIT;
          end
        end else begin
          prod_nxt  = $signed({1'b0, cnt_p1}) * psum_r[ch_r];
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        div_req.start = 1'b1;
        neg_nxt       = dvd[swaf_pkg::PROD_W-1];
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          res_nxt[ch_r] = swaf_pkg::chan_t'(qsigned[swaf_pkg::X_W-1:0]);
          ch_nxt        = ch_r + swaf_pkg::CH_W'(1);
          state_nxt     = last_ch ? ST_EMIT : ST_MUL;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hum_nxt   = res_r[0][swaf_pkg::HUM_W-1:0];
          out_temp_nxt  = res_r[1][swaf_pkg::TEMP_W-1:0];
          out_pm25_nxt  = res_r[2][swaf_pkg::PM_W-1:0];
          out_pm1_nxt   = res_r[3][swaf_pkg::PM_W-1:0];
          out_pm10_nxt  = res_r[4][swaf_pkg::PM_W-1:0];
          out_used_nxt  = cnt_r;
          out_ovf_nxt   = drop_r;
          cnt_nxt       = '0;
          drop_nxt      = 1'b0;
          ch_nxt        = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    psum_r     <= psum_nxt;
    usum_r     <= usum_nxt;
    smooth_r   <= smooth_nxt;
    res_r      <= res_nxt;
    total_r    <= total_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    out_hum_r  <= out_hum_nxt;
    out_temp_r <= out_temp_nxt;
    out_pm25_r <= out_pm25_nxt;
    out_pm1_r  <= out_pm1_nxt;
    out_pm10_r <= out_pm10_nxt;
    out_used_r <= out_used_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule
